// ===== hw/rtl/safa_pkg.sv =====
// Package for the sparse attractive-force accumulator.
// Holds payload structs, widths, constants and the controller/datapath command types.
// No dependencies.
`default_nettype none

package safa_pkg;

   localparam int COORD_W   = 24;
   localparam int AFF_W     = 32;
   localparam int ACC_W     = 40;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int Q_W       = 50;
   localparam int QUO_W     = 32;
   localparam int MULA_W    = QUO_W + 1;
   localparam int PROD_W    = MULA_W + DIFF_W;
   localparam int TERM_W    = PROD_W - QUO_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam logic [Q_W-1:0] ONE_Q32 = Q_W'(64'h1_0000_0000);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] self_x;
      logic signed [COORD_W-1:0] self_y;
      logic signed [COORD_W-1:0] nbr_x;
      logic signed [COORD_W-1:0] nbr_y;
      logic [AFF_W-1:0]          affinity;
      logic                      row_last;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] force_x;
      logic signed [ACC_W-1:0] force_y;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_QSUM,
      OP_DIV,
      OP_MULX,
      OP_MULY,
      OP_ACCY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic row_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sparse_attractive_force_accumulator_core.sv =====
// Sparse attractive-force accumulator, top level. One graph edge is taken per
// transaction: it forms q = 1 + dx^2 + dy^2, the weight w = affinity / q and adds
// w*dx, w*dy into saturating 40-bit Q24.16 sums; the last edge of a row emits the
// force and the sticky saturation flag, then clears the sums. Each edge runs
// through accept, squaring of dx and dy, the sum forming q, the bit-serial
// restoring divider for the 32-bit weight, then multiply, accumulate and finish;
// no new edge is taken before that. A finished result waits in an output
// register while the next edge is taken; a row end stalls only if the prior
// result is unread. Uses safa_pkg, safa_ctrl and safa_datapath.
`default_nettype none

module sparse_attractive_force_accumulator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  safa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output safa_pkg::rsp_type rsp_data
);
   import safa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   safa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   safa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/safa_datapath.sv =====
// Datapath: coordinate differences, shared multiplier, restoring divider,
// saturating accumulators and the result register. Uses safa_pkg.
`default_nettype none

module safa_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  safa_pkg::dp_cmd_type    cmd,
   input  safa_pkg::req_type       req_data,
   output safa_pkg::dp_status_type status,
   output safa_pkg::rsp_type       rsp_data
);
   import safa_pkg::*;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [AFF_W-1:0]         aff_ff;
   logic                     last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [Q_W-1:0]           q_ff;
   logic [Q_W-1:0]           rem_ff;
   logic [QUO_W-1:0]         w_ff;
   logic signed [ACC_W-1:0]  sum_x_ff, sum_y_ff;
   logic                     ovf_ff;
   rsp_type                  rsp_ff;

   logic signed [MULA_W-1:0] mul_a;
   logic signed [DIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [Q_W:0]             rem_shift;
   logic [Q_W:0]             rem_diff;
   logic                     quo_bit;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_sel;
   logic [ACC_W:0]           acc_sum;
   logic signed [ACC_W-1:0]  acc_sat;
   logic                     acc_ovf;

   // Shared multiplier: squares first, then weight times difference.
   always_comb begin
      unique case (cmd.op)
         OP_SQY: begin
            mul_a = {{(MULA_W-DIFF_W){dy_ff[DIFF_W-1]}}, dy_ff};
            mul_b = dy_ff;
         end
         OP_MULX: begin
            mul_a = {1'b0, w_ff};
            mul_b = dx_ff;
         end
         OP_MULY: begin
            mul_a = {1'b0, w_ff};
            mul_b = dy_ff;
         end
         default: begin
            mul_a = {{(MULA_W-DIFF_W){dx_ff[DIFF_W-1]}}, dx_ff};
            mul_b = dx_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // One restoring quotient bit per cycle; the low dividend bits are all zero.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, q_ff};
   assign quo_bit   = (rem_shift >= {1'b0, q_ff});

   // Arithmetic shift of the signed product gives the floor.
   assign term    = prod_ff[PROD_W-1:QUO_W];
   assign acc_sel = (cmd.op == OP_MULY) ? sum_x_ff : sum_y_ff;
   assign acc_sum = {acc_sel[ACC_W-1], acc_sel}
                  + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};

   always_comb begin
      acc_sat = acc_sum[ACC_W-1:0];
      acc_ovf = 1'b0;
      priority if (!acc_sum[ACC_W] && acc_sum[ACC_W-1]) begin
         acc_sat = ACC_MAX;
         acc_ovf = 1'b1;
      end else if (acc_sum[ACC_W] && !acc_sum[ACC_W-1]) begin
         acc_sat = ACC_MIN;
         acc_ovf = 1'b1;
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            dx_ff   <= {req_data.self_x[COORD_W-1], req_data.self_x}
                     - {req_data.nbr_x[COORD_W-1], req_data.nbr_x};
            dy_ff   <= {req_data.self_y[COORD_W-1], req_data.self_y}
                     - {req_data.nbr_y[COORD_W-1], req_data.nbr_y};
            aff_ff  <= req_data.affinity;
            last_ff <= req_data.row_last;
         end
         OP_SQX: begin
            prod_ff <= mul_p;
         end
         OP_SQY: begin
            q_ff    <= ONE_Q32 + Q_W'(prod_ff[SQ_W-1:0]);
            prod_ff <= mul_p;
         end
         OP_QSUM: begin
            q_ff   <= q_ff + Q_W'(prod_ff[SQ_W-1:0]);
            rem_ff <= Q_W'(aff_ff);
         end
         OP_DIV: begin
            rem_ff <= quo_bit ? rem_diff[Q_W-1:0] : rem_shift[Q_W-1:0];
            w_ff   <= {w_ff[QUO_W-2:0], quo_bit};
         end
         OP_MULX, OP_MULY: begin
            prod_ff <= mul_p;
         end
         default: begin
         end
      endcase
      if (cmd.emit) begin
         rsp_ff.force_x   <= sum_x_ff;
         rsp_ff.force_y   <= sum_y_ff;
         rsp_ff.saturated <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.emit) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.op == OP_MULY) begin
         sum_x_ff <= acc_sat;
         ovf_ff   <= ovf_ff | acc_ovf;
      end else if (cmd.op == OP_ACCY) begin
         sum_y_ff <= acc_sat;
         ovf_ff   <= ovf_ff | acc_ovf;
      end
   end

   assign status.row_last = last_ff;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/safa_ctrl.sv =====
// Controller: sequences one edge through the datapath and owns both handshakes.
// Uses safa_pkg.
`default_nettype none

module safa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  safa_pkg::dp_status_type status,
   output safa_pkg::dp_cmd_type    cmd
);
   import safa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQX,
      S_SQY,
      S_QSUM,
      S_DIV,
      S_MULX,
      S_MULY,
      S_ACCY,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.emit     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            state_in = S_QSUM;
         end
         S_QSUM: begin
            cmd.op   = OP_QSUM;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            cmd.op   = OP_MULX;
            state_in = S_MULY;
         end
         S_MULY: begin
            cmd.op   = OP_MULY;
            state_in = S_ACCY;
         end
         S_ACCY: begin
            cmd.op   = OP_ACCY;
            state_in = S_DONE;
         end
         S_DONE: begin
            // at a row end, hold here while the previous result is still unread
            if (!status.row_last) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/safa_checker.sv =====
// Port-level checker for the accumulator core, with its bind statement.
// Uses safa_pkg; attaches to sparse_attractive_force_accumulator_core.
`default_nettype none

module safa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input safa_pkg::rsp_type rsp_data
);

   // busy right after taking an edge
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted transaction");

   // a result only follows a busy stretch
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without preceding work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

endmodule

bind sparse_attractive_force_accumulator_core safa_checker u_safa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
